// ----- src/rbst_pkg.sv -----
// rbst_pkg: shared types, widths and constants for the ray/box slab test.
// Used by every module of ray_box_slab_test_unit. No dependencies.
package rbst_pkg;

	localparam int FRAC_BITS = 16;
	localparam int IN_W      = 32;
	localparam int AXES      = 3;
	localparam int LANES     = 2 * AXES;
	localparam int NUM_W     = IN_W + FRAC_BITS;
	localparam int DIV_W     = IN_W;
	localparam int T_BITS    = 48;
	localparam int MAG_W     = (NUM_W > T_BITS) ? NUM_W : T_BITS;
	localparam int TW        = MAG_W + 2;

	localparam logic signed [TW-1:0] T_INF     = {2'b01, {MAG_W{1'b0}}};
	localparam logic signed [TW-1:0] T_MAX_EXT = {{(TW-T_BITS+1){1'b0}}, {(T_BITS-1){1'b1}}};
	localparam logic signed [TW-1:0] T_MIN_EXT = {{(TW-T_BITS+1){1'b1}}, {(T_BITS-1){1'b0}}};

	typedef enum logic [1:0] {
		CLS_FINITE,
		CLS_INSIDE,
		CLS_BELOW,
		CLS_ABOVE
	} axis_cls_t;

	typedef struct packed {
		logic [DIV_W-1:0] rem;
		logic [NUM_W-1:0] num;
		logic             neg;
	} lane_t;

	typedef struct packed {
		lane_t     [LANES-1:0]          lane;
		logic      [AXES-1:0][IN_W-1:0] dmag;
		axis_cls_t [AXES-1:0]           cls;
	} div_bundle_t;

	function automatic logic signed [TW-1:0] smin(input logic signed [TW-1:0] a,
			input logic signed [TW-1:0] b);
		return (a < b) ? a : b;
	endfunction

	function automatic logic signed [TW-1:0] smax(input logic signed [TW-1:0] a,
			input logic signed [TW-1:0] b);
		return (a < b) ? b : a;
	endfunction

endpackage

// ----- src/rbst_prep.sv -----
// rbst_prep: first pipeline stage; slab differences, magnitudes, signs, axis class.
// Depends on rbst_pkg.
module rbst_prep import rbst_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_vld,
	input  logic signed [IN_W-1:0] origin_x,
	input  logic signed [IN_W-1:0] origin_y,
	input  logic signed [IN_W-1:0] origin_z,
	input  logic signed [IN_W-1:0] dir_x,
	input  logic signed [IN_W-1:0] dir_y,
	input  logic signed [IN_W-1:0] dir_z,
	input  logic signed [IN_W-1:0] box_min_x,
	input  logic signed [IN_W-1:0] box_min_y,
	input  logic signed [IN_W-1:0] box_min_z,
	input  logic signed [IN_W-1:0] box_max_x,
	input  logic signed [IN_W-1:0] box_max_y,
	input  logic signed [IN_W-1:0] box_max_z,
	output logic                   out_vld,
	output div_bundle_t            out_b
);

	logic signed [IN_W-1:0] org [AXES];
	logic signed [IN_W-1:0] dir [AXES];
	logic signed [IN_W-1:0] bmn [AXES];
	logic signed [IN_W-1:0] bmx [AXES];
	logic signed [IN_W:0]   lo  [AXES];
	logic signed [IN_W:0]   hi  [AXES];
	logic signed [IN_W:0]   lo_n [AXES];
	logic signed [IN_W:0]   hi_n [AXES];
	logic signed [IN_W:0]   dir_n [AXES];
	div_bundle_t            nxt;
	div_bundle_t            b_s1;
	logic                   vld_s1;

	assign org = '{origin_x, origin_y, origin_z};
	assign dir = '{dir_x, dir_y, dir_z};
	assign bmn = '{box_min_x, box_min_y, box_min_z};
	assign bmx = '{box_max_x, box_max_y, box_max_z};

	always_comb begin
		nxt = '0;
		for (int a = 0; a < AXES; a++) begin
			lo[a]    = {bmn[a][IN_W-1], bmn[a]} - {org[a][IN_W-1], org[a]};
			hi[a]    = {bmx[a][IN_W-1], bmx[a]} - {org[a][IN_W-1], org[a]};
			lo_n[a]  = -lo[a];
			hi_n[a]  = -hi[a];
			dir_n[a] = -{dir[a][IN_W-1], dir[a]};
			nxt.dmag[a] = dir[a][IN_W-1] ? dir_n[a][IN_W-1:0] : dir[a];
			nxt.lane[2*a].rem   = '0;
			nxt.lane[2*a].neg   = lo[a][IN_W] ^ dir[a][IN_W-1];
			nxt.lane[2*a].num   = {(lo[a][IN_W] ? lo_n[a][IN_W-1:0] : lo[a][IN_W-1:0]),
				{FRAC_BITS{1'b0}}};
			nxt.lane[2*a+1].rem = '0;
			nxt.lane[2*a+1].neg = hi[a][IN_W] ^ dir[a][IN_W-1];
			nxt.lane[2*a+1].num = {(hi[a][IN_W] ? hi_n[a][IN_W-1:0] : hi[a][IN_W-1:0]),
				{FRAC_BITS{1'b0}}};
			if (dir[a] != '0)
				nxt.cls[a] = CLS_FINITE;
			else if (lo[a] > 0)
				nxt.cls[a] = CLS_BELOW;
			else if (hi[a] < 0)
				nxt.cls[a] = CLS_ABOVE;
			else
				nxt.cls[a] = CLS_INSIDE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b_s1 <= nxt;
		end
	end

	assign out_vld = vld_s1;
	assign out_b   = b_s1;

endmodule

// ----- src/rbst_div_step.sv -----
// rbst_div_step: one restoring-division step for all six slab lanes, registered.
// Depends on rbst_pkg.
module rbst_div_step import rbst_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_vld,
	input  div_bundle_t in_b,
	output logic        out_vld,
	output div_bundle_t out_b
);

	logic [DIV_W:0] rem2 [LANES];
	logic [DIV_W:0] sub  [LANES];
	logic           ge   [LANES];
	div_bundle_t    nxt;
	div_bundle_t    b_s;
	logic           vld_s;

	always_comb begin
		nxt = in_b;
		for (int l = 0; l < LANES; l++) begin
			rem2[l] = {in_b.lane[l].rem, in_b.lane[l].num[NUM_W-1]};
			sub[l]  = rem2[l] - {1'b0, in_b.dmag[l>>1]};
			ge[l]   = rem2[l] >= {1'b0, in_b.dmag[l>>1]};
			nxt.lane[l].rem = ge[l] ? sub[l][DIV_W-1:0] : rem2[l][DIV_W-1:0];
			nxt.lane[l].num = {in_b.lane[l].num[NUM_W-2:0], ge[l]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= 1'b0;
		end else if (en) begin
			vld_s <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b_s <= nxt;
		end
	end

	assign out_vld = vld_s;
	assign out_b   = b_s;

endmodule

// ----- src/rbst_reduce.sv -----
// rbst_reduce: signs the quotients, builds tmin/tmax, decides hit and saturates.
// Three register stages, the last one drives the output channel. Depends on rbst_pkg.
module rbst_reduce import rbst_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_vld,
	input  div_bundle_t              in_b,
	output logic                     out_vld,
	output logic                     hit,
	output logic signed [T_BITS-1:0] t_value
);

	logic signed [TW-1:0] q     [LANES];
	logic signed [TW-1:0] n_c   [AXES];
	logic signed [TW-1:0] f_c   [AXES];
	logic                 fm_c;
	logic signed [TW-1:0] n_s1  [AXES];
	logic signed [TW-1:0] f_s1  [AXES];
	logic                 fm_s1;
	logic                 vld_s1;
	logic signed [TW-1:0] tmin_s2;
	logic signed [TW-1:0] tmax_s2;
	logic                 fm_s2;
	logic                 vld_s2;
	logic                 miss;
	logic signed [TW-1:0] sel;
	logic signed [T_BITS-1:0] sat;
	logic                 hit_s3;
	logic signed [T_BITS-1:0] t_s3;
	logic                 vld_s3;

	always_comb begin
		fm_c = 1'b0;
		for (int l = 0; l < LANES; l++) begin
			q[l] = in_b.lane[l].neg ? -$signed({{(TW-NUM_W){1'b0}}, in_b.lane[l].num})
				: $signed({{(TW-NUM_W){1'b0}}, in_b.lane[l].num});
		end
		for (int a = 0; a < AXES; a++) begin
			case (in_b.cls[a])
				CLS_FINITE: begin
					n_c[a] = smin(q[2*a], q[2*a+1]);
					f_c[a] = smax(q[2*a], q[2*a+1]);
				end
				CLS_BELOW: begin
					n_c[a] = T_INF;
					f_c[a] = T_INF;
					fm_c   = 1'b1;
				end
				CLS_ABOVE: begin
					n_c[a] = -T_INF;
					f_c[a] = -T_INF;
					fm_c   = 1'b1;
				end
				default: begin
					n_c[a] = -T_INF;
					f_c[a] = T_INF;
				end
			endcase
		end
	end

	always_comb begin
		miss = fm_s2 || (tmax_s2 < 0) || (tmin_s2 > tmax_s2);
		sel  = miss ? tmax_s2 : tmin_s2;
		if (sel > T_MAX_EXT)
			sat = T_MAX_EXT[T_BITS-1:0];
		else if (sel < T_MIN_EXT)
			sat = T_MIN_EXT[T_BITS-1:0];
		else
			sat = sel[T_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s1    <= n_c;
			f_s1    <= f_c;
			fm_s1   <= fm_c;
			tmin_s2 <= smax(smax(n_s1[0], n_s1[1]), n_s1[2]);
			tmax_s2 <= smin(smin(f_s1[0], f_s1[1]), f_s1[2]);
			fm_s2   <= fm_s1;
			hit_s3  <= !miss;
			t_s3    <= sat;
		end
	end

	assign out_vld = vld_s3;
	assign hit     = hit_s3;
	assign t_value = t_s3;

endmodule

// ----- src/ray_box_slab_test_unit.sv -----
// ray_box_slab_test_unit: top level of the pipelined ray versus axis-aligned box test.
// Instantiates rbst_prep, NUM_W x rbst_div_step and rbst_reduce; depends on rbst_pkg.
//
// Usage:
//   Input channel: in_valid / in_stall with origin, direction and box corners,
//   all signed fixed point with FRAC_BITS fraction bits. A transfer happens on
//   a rising edge with in_valid high and in_stall low.
//   Output channel: out_valid / out_stall with hit and t_value (tmin on a hit,
//   tmax on a miss, saturated to 48 bits). One result per input transfer, in order.
// Pipeline: one set-up stage, one restoring-division bit per stage for the six
//   slab quotients, and three stages for slab ordering, tmin/tmax reduction and
//   hit/saturation.
// Throughput: one transfer per cycle unless the output stalls; the division chain is fully pipelined.
// Stall: the whole pipeline holds while out_valid is high and out_stall is high;
//   in_stall follows that condition, so no item is lost or repeated.
// Reset: arst_n clears every stage valid bit asynchronously; the pipeline is
//   empty and ready after reset.
module ray_box_slab_test_unit import rbst_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [IN_W-1:0]   origin_x,
	input  logic signed [IN_W-1:0]   origin_y,
	input  logic signed [IN_W-1:0]   origin_z,
	input  logic signed [IN_W-1:0]   dir_x,
	input  logic signed [IN_W-1:0]   dir_y,
	input  logic signed [IN_W-1:0]   dir_z,
	input  logic signed [IN_W-1:0]   box_min_x,
	input  logic signed [IN_W-1:0]   box_min_y,
	input  logic signed [IN_W-1:0]   box_min_z,
	input  logic signed [IN_W-1:0]   box_max_x,
	input  logic signed [IN_W-1:0]   box_max_y,
	input  logic signed [IN_W-1:0]   box_max_z,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     hit,
	output logic signed [T_BITS-1:0] t_value
);

	logic        adv;
	logic        chain_v [NUM_W+1];
	div_bundle_t chain_b [NUM_W+1];

	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	rbst_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_vld    (in_valid),
		.origin_x  (origin_x),
		.origin_y  (origin_y),
		.origin_z  (origin_z),
		.dir_x     (dir_x),
		.dir_y     (dir_y),
		.dir_z     (dir_z),
		.box_min_x (box_min_x),
		.box_min_y (box_min_y),
		.box_min_z (box_min_z),
		.box_max_x (box_max_x),
		.box_max_y (box_max_y),
		.box_max_z (box_max_z),
		.out_vld   (chain_v[0]),
		.out_b     (chain_b[0])
	);

	for (genvar i = 0; i < NUM_W; i++) begin : g_div
		rbst_div_step u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (adv),
			.in_vld  (chain_v[i]),
			.in_b    (chain_b[i]),
			.out_vld (chain_v[i+1]),
			.out_b   (chain_b[i+1])
		);
	end

	rbst_reduce u_reduce (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.in_vld  (chain_v[NUM_W]),
		.in_b    (chain_b[NUM_W]),
		.out_vld (out_valid),
		.hit     (hit),
		.t_value (t_value)
	);

endmodule

// ----- src/rbst_checker.sv -----
// rbst_checker: port-level assertions for ray_box_slab_test_unit, bound to the top.
// Depends on rbst_pkg.
module rbst_checker import rbst_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_stall,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic                     hit,
	input logic signed [T_BITS-1:0] t_value
);

	a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while output not blocked");

	a_flow_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall) |-> !in_stall)
		else $error("input stalled during output transfer");

	a_out_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("result dropped under stall");

	a_out_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> ($stable(hit) && $stable(t_value)))
		else $error("result changed under stall");

endmodule

bind ray_box_slab_test_unit rbst_checker u_rbst_checker (.*);

// ----- test/rbst_checker.sv -----
// rbst_scoreboard: watches both channels of ray_box_slab_test_unit, predicts each
// result from the accepted ray/box and compares in order. Depends on rbst_pkg.
module rbst_scoreboard import rbst_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_stall,
	input  logic signed [IN_W-1:0]   origin_x,
	input  logic signed [IN_W-1:0]   origin_y,
	input  logic signed [IN_W-1:0]   origin_z,
	input  logic signed [IN_W-1:0]   dir_x,
	input  logic signed [IN_W-1:0]   dir_y,
	input  logic signed [IN_W-1:0]   dir_z,
	input  logic signed [IN_W-1:0]   box_min_x,
	input  logic signed [IN_W-1:0]   box_min_y,
	input  logic signed [IN_W-1:0]   box_min_z,
	input  logic signed [IN_W-1:0]   box_max_x,
	input  logic signed [IN_W-1:0]   box_max_y,
	input  logic signed [IN_W-1:0]   box_max_z,
	input  logic                     out_valid,
	input  logic                     out_stall,
	input  logic                     hit,
	input  logic signed [T_BITS-1:0] t_value,
	output int                       errors,
	output int                       pending,
	output int                       hits_seen,
	output int                       misses_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic                     hit;
		logic signed [T_BITS-1:0] t;
	} slab_result_t;

	localparam longint INF = longint'(1) <<< 60;
	localparam longint TMAX = (longint'(1) <<< 47) - 1;
	localparam longint TMIN = -(longint'(1) <<< 47);

	slab_result_t expected_hits[$];

	function automatic slab_result_t slab_test(input logic signed [IN_W-1:0] o[3],
			input logic signed [IN_W-1:0] d[3], input logic signed [IN_W-1:0] lo_c[3],
			input logic signed [IN_W-1:0] hi_c[3]);
		longint tmin, tmax, lo, hi, a, b, n, f, tsel;
		bit miss;
		slab_result_t r;
		tmin = -INF;
		tmax = INF;
		miss = 0;
		for (int k = 0; k < 3; k++) begin
			lo = longint'(lo_c[k]) - longint'(o[k]);
			hi = longint'(hi_c[k]) - longint'(o[k]);
			if (d[k] == 0) begin
				if (lo > 0) begin
					n = INF; f = INF; miss = 1;
				end else if (hi < 0) begin
					n = -INF; f = -INF; miss = 1;
				end else begin
					n = -INF; f = INF;
				end
			end else begin
				a = (lo * (longint'(1) <<< FRAC_BITS)) / longint'(d[k]);
				b = (hi * (longint'(1) <<< FRAC_BITS)) / longint'(d[k]);
				n = (a < b) ? a : b;
				f = (a < b) ? b : a;
			end
			if (n > tmin) tmin = n;
			if (f < tmax) tmax = f;
		end
		r.hit = !(miss || tmax < 0 || tmin > tmax);
		tsel = r.hit ? tmin : tmax;
		if (tsel > TMAX) tsel = TMAX;
		if (tsel < TMIN) tsel = TMIN;
		r.t = tsel[T_BITS-1:0];
		return r;
	endfunction

	task automatic report(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	initial begin
		errors = 0;
		hits_seen = 0;
		misses_seen = 0;
	end

	assign pending = expected_hits.size();

	always @(posedge clk) begin
		slab_result_t e;
		if (arst_n && in_valid && !in_stall)
			expected_hits.insert(expected_hits.size(), slab_test(
				'{origin_x, origin_y, origin_z},
				'{dir_x, dir_y, dir_z}, '{box_min_x, box_min_y, box_min_z},
				'{box_max_x, box_max_y, box_max_z}));
		if (arst_n && out_valid && !out_stall) begin
			if (expected_hits.size() == 0) begin
				report("result transfer with nothing expected");
			end else begin
				e = expected_hits.pop_front();
				if (hit !== e.hit)
					report($sformatf("hit %b, expected %b", hit, e.hit));
				if (t_value !== e.t)
					report($sformatf("t_value %0d, expected %0d", t_value, e.t));
				if (e.hit) hits_seen++;
				else misses_seen++;
			end
		end
	end
endmodule

// ----- test/tb_ray_box_slab_test_unit.sv -----
// tb_ray_box_slab_test_unit: drives directed and random rays into the slab test
// unit under varying idle/stall; verdict from rbst_scoreboard. Depends on rbst_pkg.
module tb_ray_box_slab_test_unit;
	import rbst_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG = 5000;
	localparam int N_RANDOM = 1200;

	logic clk, arst_n, in_valid, in_stall, out_valid, out_stall, hit;
	logic signed [IN_W-1:0] f[12];
	logic signed [T_BITS-1:0] t_value;
	int errors, pending, hits_seen, misses_seen;
	int send_idle, recv_idle, idle_cycles, sent;

	ray_box_slab_test_unit u_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.origin_x(f[0]), .origin_y(f[1]), .origin_z(f[2]),
		.dir_x(f[3]), .dir_y(f[4]), .dir_z(f[5]),
		.box_min_x(f[6]), .box_min_y(f[7]), .box_min_z(f[8]),
		.box_max_x(f[9]), .box_max_y(f[10]), .box_max_z(f[11]),
		.out_valid(out_valid), .out_stall(out_stall), .hit(hit), .t_value(t_value)
	);

	rbst_scoreboard u_checker (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.origin_x(f[0]), .origin_y(f[1]), .origin_z(f[2]),
		.dir_x(f[3]), .dir_y(f[4]), .dir_z(f[5]),
		.box_min_x(f[6]), .box_min_y(f[7]), .box_min_z(f[8]),
		.box_max_x(f[9]), .box_max_y(f[10]), .box_max_z(f[11]),
		.out_valid(out_valid), .out_stall(out_stall), .hit(hit), .t_value(t_value),
		.errors(errors), .pending(pending), .hits_seen(hits_seen),
		.misses_seen(misses_seen)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_idle);

	always @(posedge clk) begin
		if (!(out_valid && !out_stall) && !(in_valid && !in_stall)) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles > WATCHDOG) begin
				$display("tb_ray_box_slab_test_unit: done, errors");
				$finish;
			end
		end else begin
			idle_cycles <= 0;
		end
	end

	function automatic logic signed [IN_W-1:0] rand_coord();
		case ($urandom_range(5))
			0: return $urandom;
			1: return $urandom_range(3) == 0 ? 32'sd0 :
				($urandom_range(1) ? 32'sh8000_0000 : 32'sh7fff_ffff);
			default: return $signed($urandom_range(32'h000f_ffff)) - 32'sh0008_0000;
		endcase
	endfunction

	// one transfer; gaps before it at the sender's idle rate
	task automatic send_ray(input logic signed [IN_W-1:0] v[12]);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		for (int i = 0; i < 12; i++) f[i] <= v[i];
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent++;
	endtask

	task automatic random_ray();
		logic signed [IN_W-1:0] v[12];
		logic signed [IN_W-1:0] a, b;
		for (int k = 0; k < 3; k++) begin
			v[k] = rand_coord();
			v[3 + k] = ($urandom_range(7) == 0) ? 32'sd0 : rand_coord();
			a = rand_coord();
			b = rand_coord();
			if ($urandom_range(9) != 0 && a > b) begin
				v[6 + k] = b; v[9 + k] = a;
			end else begin
				v[6 + k] = a; v[9 + k] = b;
			end
		end
		send_ray(v);
	endtask

	initial begin
		localparam logic signed [IN_W-1:0] ONE = 32'sh0001_0000;
		localparam logic signed [IN_W-1:0] MX = 32'sh7fff_ffff;
		localparam logic signed [IN_W-1:0] MN = 32'sh8000_0000;
		arst_n = 0;
		in_valid = 0;
		out_stall = 0;
		idle_cycles = 0;
		sent = 0;
		send_idle = 0;
		recv_idle = 0;
		for (int i = 0; i < 12; i++) f[i] = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// plain hit along +x
		send_ray('{0, 0, 0, ONE, ONE/2, ONE/4, ONE, -ONE, -ONE, 2*ONE, ONE, ONE});
		// box behind origin
		send_ray('{0, 0, 0, -ONE, 0, 0, ONE, -ONE, -ONE, 2*ONE, ONE, ONE});
		// origin inside box
		send_ray('{0, 0, 0, ONE, -ONE, ONE, -ONE, -ONE, -ONE, ONE, ONE, ONE});
		// zero direction: inside, below, above the slab
		send_ray('{0, 0, 0, ONE, 0, 0, ONE, -ONE, -ONE, 2*ONE, ONE, ONE});
		send_ray('{0, 0, 0, ONE, 0, 0, ONE, ONE, -ONE, 2*ONE, 2*ONE, ONE});
		send_ray('{0, 0, 0, ONE, 0, 0, ONE, -2*ONE, -ONE, 2*ONE, -ONE, ONE});
		// all directions zero, origin inside and outside
		send_ray('{0, 0, 0, 0, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE});
		send_ray('{5*ONE, 0, 0, 0, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE});
		// inverted box, nonzero and zero direction
		send_ray('{0, 0, 0, ONE, ONE, ONE, 2*ONE, 2*ONE, 2*ONE, ONE, ONE, ONE});
		send_ray('{0, 0, 0, ONE, 0, ONE, ONE, ONE, ONE, 2*ONE, -ONE, 2*ONE});
		// extremes: saturation of large positive t, tiny directions
		send_ray('{MN, MN, MN, 1, 1, 1, MX, MX, MX, MX, MX, MX});
		send_ray('{MX, MX, MX, -1, -1, -1, MN, MN, MN, MN, MN, MN});
		send_ray('{MN, MX, 0, MX, MN, 1, MN, MN, MN, MX, MX, MX});
		send_ray('{MX, MN, -1, MN, MX, -1, MN, MN, MN, MX, MX, MX});
		send_ray('{-1, -1, -1, MN, MN, MN, MN, MN, MN, MX, MX, MX});
		send_ray('{MX, MX, MX, MX, MX, MX, MX, MX, MX, MX, MX, MX});
		send_ray('{MN, MN, MN, MN, MN, MN, MN, MN, MN, MN, MN, MN});
		// grazing: tmin equals tmax
		send_ray('{0, 0, 0, ONE, ONE, 0, ONE, ONE, 0, ONE, 2*ONE, 0});

		send_idle = 30; recv_idle = 65;
		repeat (N_RANDOM / 3) random_ray();
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		send_idle = 65; recv_idle = 30;
		repeat (N_RANDOM / 3) random_ray();
		send_idle = 0; recv_idle = 0;
		repeat (N_RANDOM / 3) random_ray();
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);

		$display("%0d rays sent: directed extremes, zero-direction and inverted-box cases,",
			sent);
		$display("random rays under three idle/stall mixes; %0d hits, %0d misses",
			hits_seen, misses_seen);
		if (errors == 0)
			$display("tb_ray_box_slab_test_unit: done, clean");
		else
			$display("tb_ray_box_slab_test_unit: done, errors");
		$finish;
	end
endmodule
